>>> rtl/sine_note_adsr_synth_macros.svh
// Assertion macros for the note synthesiser.
// No dependencies.
`ifndef SINE_NOTE_ADSR_SYNTH_MACROS_SVH
`define SINE_NOTE_ADSR_SYNTH_MACROS_SVH
`define SNAS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("check failed");
`define SNAS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("check failed");
`endif

>>> rtl/snas_pkg.sv
// Package for the note synthesiser: constants, pitch table, command codes.
// No dependencies.
`default_nettype none
package snas_pkg;
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int NOTE_COUNT       = 128;
    localparam int DURATION_BITS    = 24;
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;
    localparam logic [2:0] REG_RATE = 3'd0;
    localparam logic [2:0] REG_ATT  = 3'd1;
    localparam logic [2:0] REG_DEC  = 3'd2;
    localparam logic [2:0] REG_REL  = 3'd3;
    localparam logic [2:0] REG_SUS  = 3'd4;

    function automatic logic [31:0] top_octave(input logic [3:0] s);
        logic [31:0] r;
        case (s)
            4'd0:  r = 32'd548668578;
            4'd1:  r = 32'd581294109;
            4'd2:  r = 32'd615859655;
            4'd3:  r = 32'd652480576;
            4'd4:  r = 32'd691279090;
            4'd5:  r = 32'd732384684;
            4'd6:  r = 32'd775934544;
            4'd7:  r = 32'd822074012;
            4'd8:  r = 32'd870957077;
            4'd9:  r = 32'd922746880;
            4'd10: r = 32'd977616265;
            4'd11: r = 32'd1035748353;
            default: r = 32'd0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

>>> rtl/snas_divider.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing else.
`default_nettype none
module snas_divider (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [47:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             busy,
    output logic [47:0]      quotient
);
    logic [47:0] q_reg, q_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] d_reg, d_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;

    always_comb begin
        q_next = q_reg;
        rem_next = rem_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg[31:0], q_reg[47]} - {1'b0, d_reg};
        if (start) begin
            q_next = dividend;
            rem_next = '0;
            d_next = divisor;
            cnt_next = 6'd48;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[32]) begin
                rem_next = trial;
                q_next = {q_reg[46:0], 1'b1};
            end else begin
                rem_next = {rem_reg[31:0], q_reg[47]};
                q_next = {q_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
        rem_reg <= rem_next;
        d_reg <= d_next;
        cnt_reg <= cnt_next;
        if (!aresetn) busy_reg <= 1'b0;
        else busy_reg <= busy_next;
    end
    assign busy = busy_reg;
    assign quotient = q_reg;
endmodule
`default_nettype wire

>>> rtl/snas_mult.sv
// Registered 32x32 multiplier, shared by all sequencer steps.
// Depends on nothing else.
`default_nettype none
module snas_mult (
    input  wire logic        aclk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic [63:0]      p
);
    logic [63:0] p_reg;
    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end
    assign p = p_reg;
endmodule
`default_nettype wire

>>> rtl/sine_note_adsr_synth.sv
// Note synthesiser top: note/silence loads, then one sample per tick transfer.
// Note load: ready again after the divide and the phase multiply; silence load: ready again
// at once. Note tick: result after the envelope divide, skipped in sustain; idle or silent
// tick: result straight from the output state. One item in flight at a time.
// Synchronous active-low reset: idle, counters zero, registers at their defaults.
// Depends on snas_pkg, snas_divider, snas_mult, sine_note_adsr_synth_macros.svh.
`default_nettype none
`include "sine_note_adsr_synth_macros.svh"
module sine_note_adsr_synth #(
    parameter int SINE_TABLE_DEPTH = snas_pkg::SINE_TABLE_DEPTH,
    parameter int DURATION_BITS    = snas_pkg::DURATION_BITS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_command,
    input  wire logic        s_is_silence,
    input  wire logic [6:0]  s_note_number,
    input  wire logic [6:0]  s_velocity,
    input  wire logic [23:0] s_duration_samples,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic signed [15:0] m_sample,
    output logic             m_last_of_event,
    output logic             m_active,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [16:0] cfg_data
);
    localparam int TB = $clog2(SINE_TABLE_DEPTH);
    localparam logic [23:0] DMASK = 24'((64'd1 << DURATION_BITS) - 64'd1);
    // ceil(2^30/127): exact x/127 for x below 2^23
    localparam logic [31:0] AMP_RECIP = 32'd8454661;

    localparam logic [4:0] S_IDLE = 5'd0, S_LDIV = 5'd1, S_LWAIT = 5'd2,
        S_LPH = 5'd3, S_LPHW = 5'd4, S_ENV = 5'd5, S_EDIV = 5'd6,
        S_Z2 = 5'd7, S_T1 = 5'd8, S_T2 = 5'd9, S_T3 = 5'd10,
        S_T4 = 5'd11, S_T5 = 5'd12, S_AMP = 5'd13, S_A2 = 5'd14,
        S_ENVM = 5'd15, S_E2 = 5'd16, S_OUT = 5'd17, S_DONE = 5'd18;

    localparam logic [1:0] ENV_ATT = 2'd0, ENV_DEC = 2'd1, ENV_REL = 2'd2;

    logic [4:0]  st_reg, st_next;
    logic [1:0]  ret_reg, ret_next;
    logic [16:0] rate_reg;
    logic [15:0] att_reg, dec_reg, rel_reg, sus_reg;
    logic [31:0] elap_reg, elap_next, ph_reg, ph_next, inc_reg, inc_next;
    logic [23:0] pos_reg, pos_next, len_reg, len_next;
    logic [15:0] amp_reg, amp_next;
    logic        sil_reg, sil_next, act_reg, act_next;
    logic [31:0] z_reg, z_next, z2_reg, z2_next, t_reg, t_next;
    logic [16:0] env_reg, env_next;
    logic        neg_reg, neg_next, envdiv_reg, envdiv_next;
    logic [31:0] ma_reg, ma_next, mb_reg, mb_next;
    logic [63:0] mp;
    logic        dstart;
    logic [47:0] dnd;
    logic [31:0] dsr;
    logic        dbusy;
    logic [47:0] dq;
    logic        mv_reg, mv_next, ml_reg, ml_next, ma_o_reg, ma_o_next;
    logic [15:0] ms_reg, ms_next;

    logic [TB-1:0] idx;
    logic [15:0]   turn;
    logic [31:0]   zf;
    logic [3:0]    oct, semi;
    logic [31:0]   freq;
    logic [31:0]   vprod;
    logic [63:0]   sh15, mag;
    logic [16:0]   qs;
    logic [23:0]   lp;
    logic [31:0]   pa;
    logic [16:0]   envv;

    snas_divider u_div (.aclk, .aresetn, .start(dstart), .dividend(dnd), .divisor(dsr),
        .busy(dbusy), .quotient(dq));
    snas_mult u_mul (.aclk, .a(ma_reg), .b(mb_reg), .p(mp));

    assign s_ready = (st_reg == S_IDLE);
    assign cfg_ready = (st_reg == S_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg <= 17'd16000; att_reg <= 16'd800; dec_reg <= 16'd1600;
            rel_reg <= 16'd3200; sus_reg <= 16'd52429;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                snas_pkg::REG_RATE: rate_reg <= cfg_data;
                snas_pkg::REG_ATT:  att_reg <= cfg_data[15:0];
                snas_pkg::REG_DEC:  dec_reg <= cfg_data[15:0];
                snas_pkg::REG_REL:  rel_reg <= cfg_data[15:0];
                snas_pkg::REG_SUS:  sus_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // sine index folded to quarter wave; note split into octave and semitone
    always_comb begin
        idx = ph_reg[31 -: TB];
        turn = 16'(({16'd0, idx} << 16) >> TB);
        zf = {17'd0, turn[13:0], 1'b0};
        if (turn[14]) zf = 32'd32768 - zf;
        oct = 4'd0;
        for (int k = 1; k <= 10; k++) begin
            if (s_note_number >= 7'(12 * k)) oct = 4'(k);
        end
        semi = 4'(s_note_number - 7'(oct) * 7'd12);
        freq = snas_pkg::top_octave(semi) >> (4'd10 - oct);
        vprod = 32'(s_velocity) * 32'd45875 + 32'd63;
        sh15 = mp >> 15;
        mag = mp >> 16;
        qs = (sh15 > 64'd32767) ? 17'd32767 : sh15[16:0];
        lp = pos_reg + 24'd1;
        pa = {8'd0, pos_reg} - {16'd0, att_reg};
        envv = !envdiv_reg ? env_reg :
               (ret_reg == ENV_DEC) ? 17'd65536 - dq[16:0] : dq[16:0];
    end

    always_comb begin
        st_next = st_reg; ret_next = ret_reg;
        elap_next = elap_reg; ph_next = ph_reg; inc_next = inc_reg;
        pos_next = pos_reg; len_next = len_reg; amp_next = amp_reg;
        sil_next = sil_reg; act_next = act_reg;
        z_next = z_reg; z2_next = z2_reg; t_next = t_reg; env_next = env_reg;
        neg_next = neg_reg; envdiv_next = envdiv_reg;
        ma_next = ma_reg; mb_next = mb_reg;
        mv_next = mv_reg; ml_next = ml_reg; ma_o_next = ma_o_reg; ms_next = ms_reg;
        dstart = 1'b0; dnd = '0; dsr = 32'd1;
        if (mv_reg && m_ready) mv_next = 1'b0;
        case (st_reg)
            S_IDLE: if (s_valid && s_ready) begin
                if (s_command == snas_pkg::CMD_LOAD) begin
                    sil_next = s_is_silence;
                    len_next = s_duration_samples & DMASK;
                    pos_next = '0;
                    act_next = (s_duration_samples & DMASK) != 24'd0;
                    if (s_is_silence) begin
                        inc_next = '0; amp_next = '0; ph_next = '0;
                    end else begin
                        dstart = 1'b1;
                        dnd = {freq, 16'd0};
                        dsr = (rate_reg == 17'd0) ? 32'd1 : {15'd0, rate_reg};
                        ma_next = vprod; mb_next = AMP_RECIP;
                        st_next = S_LDIV;
                    end
                end else if (!act_reg || sil_reg) begin
                    t_next = '0; st_next = S_DONE;
                end else begin
                    z_next = zf; neg_next = turn[15];
                    envdiv_next = 1'b1;
                    // envelope dividend goes through the multiplier first
                    if ({8'd0, pos_reg} < {16'd0, att_reg}) begin
                        ma_next = {8'd0, pos_reg}; mb_next = 32'd65536;
                        ret_next = ENV_ATT;
                    end else if ({8'd0, pos_reg} < {16'd0, att_reg} + {16'd0, dec_reg}) begin
                        ma_next = pa; mb_next = 32'd65536 - {16'd0, sus_reg};
                        ret_next = ENV_DEC;
                    end else if ({8'd0, pos_reg} + {16'd0, rel_reg} < {8'd0, len_reg}) begin
                        envdiv_next = 1'b0; env_next = {1'b0, sus_reg};
                    end else begin
                        ma_next = {16'd0, sus_reg}; mb_next = {8'd0, len_reg - pos_reg};
                        ret_next = ENV_REL;
                    end
                    st_next = S_ENV;
                end
            end
            S_LDIV: st_next = S_LWAIT;
            S_LWAIT: if (!dbusy) begin
                amp_next = mp[45:30];
                inc_next = dq[31:0];
                ma_next = dq[31:0]; mb_next = elap_reg;
                st_next = S_LPH;
            end
            S_LPH: st_next = S_LPHW;
            S_LPHW: begin ph_next = mp[31:0]; st_next = S_IDLE; end
            S_ENV: begin
                ma_next = z_reg; mb_next = z_reg;
                st_next = S_EDIV;
            end
            S_EDIV: begin
                dstart = envdiv_reg;
                dnd = mp[47:0];
                case (ret_reg)
                    ENV_ATT: dsr = {16'd0, att_reg};
                    ENV_DEC: dsr = {16'd0, dec_reg};
                    default: dsr = {16'd0, rel_reg};
                endcase
                st_next = S_Z2;
            end
            S_Z2: begin
                z2_next = sh15[31:0];
                ma_next = 32'd2320; mb_next = sh15[31:0]; st_next = S_T1;
            end
            S_T1: st_next = S_T2;
            S_T2: begin
                ma_next = 32'd21024 - sh15[31:0]; mb_next = z2_reg; st_next = S_T3;
            end
            S_T3: st_next = S_T4;
            S_T4: begin
                ma_next = 32'd51472 - sh15[31:0]; mb_next = z_reg; st_next = S_T5;
            end
            S_T5: st_next = S_AMP;
            S_AMP: begin
                ma_next = {15'd0, qs}; mb_next = {16'd0, amp_reg}; st_next = S_A2;
            end
            S_A2: st_next = S_ENVM;
            S_ENVM: if (!dbusy) begin
                ma_next = mag[31:0]; mb_next = {15'd0, envv}; st_next = S_E2;
            end
            S_E2: st_next = S_OUT;
            S_OUT: begin
                t_next = neg_reg ? 32'd0 - {16'd0, mag[15:0]} : {16'd0, mag[15:0]};
                st_next = S_DONE;
            end
            S_DONE: if (!mv_reg || m_ready) begin
                ms_next = t_reg[15:0];
                mv_next = 1'b1;
                if (act_reg) begin
                    ml_next = lp >= len_reg;
                    ma_o_next = 1'b1;
                    pos_next = lp & DMASK;
                    ph_next = ph_reg + inc_reg;
                    elap_next = elap_reg + 32'd1;
                    if (lp >= len_reg) act_next = 1'b0;
                end else begin
                    ml_next = 1'b0; ma_o_next = 1'b0;
                end
                st_next = S_IDLE;
            end
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE; ret_reg <= '0;
            elap_reg <= '0; ph_reg <= '0; inc_reg <= '0; pos_reg <= '0; len_reg <= '0;
            amp_reg <= '0; sil_reg <= 1'b0; act_reg <= 1'b0;
            mv_reg <= 1'b0; neg_reg <= 1'b0; envdiv_reg <= 1'b0; t_reg <= '0;
        end else begin
            st_reg <= st_next; ret_reg <= ret_next;
            elap_reg <= elap_next; ph_reg <= ph_next; inc_reg <= inc_next;
            pos_reg <= pos_next; len_reg <= len_next; amp_reg <= amp_next;
            sil_reg <= sil_next; act_reg <= act_next;
            mv_reg <= mv_next; neg_reg <= neg_next; envdiv_reg <= envdiv_next;
            t_reg <= t_next;
        end
        z_reg <= z_next; z2_reg <= z2_next; env_reg <= env_next;
        ma_reg <= ma_next; mb_reg <= mb_next;
        ml_reg <= ml_next; ma_o_reg <= ma_o_next;
        ms_reg <= ms_next;
    end

    assign m_valid = mv_reg;
    assign m_sample = ms_reg;
    assign m_last_of_event = ml_reg;
    assign m_active = ma_o_reg;

    `SNAS_ASSERT_IMP(a_busy_not_ready, st_reg != S_IDLE, !s_ready)
    `SNAS_ASSERT_IMP(a_idle_zero, m_valid && !m_active, m_sample == 16'd0 && !m_last_of_event)
    `SNAS_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_sample))
endmodule
`default_nettype wire

>>> tb/tb_sine_note_adsr_synth.sv
// Self-checking bench for sine_note_adsr_synth: directed table then random note/tick traffic.
// Depends on snas_pkg and the RTL of sine_note_adsr_synth; the expected samples come
// from a behavioural model of the oscillator and envelope held in this file.
`timescale 1ns / 100ps
`default_nettype none
module tb_sine_note_adsr_synth;

    typedef struct packed {
        logic        cmd;
        logic        sil;
        logic [6:0]  note;
        logic [6:0]  vel;
        logic [23:0] dur;
    } ev_t;

    typedef struct packed {
        logic signed [15:0] smp;
        logic               last;
        logic               act;
    } smp_t;

    typedef struct {
        ev_t  ev;
        logic fixed;
        smp_t want;
    } row_t;

    localparam int WATCHDOG = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0, s_command = 1'b0, s_is_silence = 1'b0;
    logic [6:0] s_note_number = '0, s_velocity = '0;
    logic [23:0] s_duration_samples = '0;
    logic s_ready;
    logic m_valid, m_last_of_event, m_active;
    logic signed [15:0] m_sample;
    logic m_ready = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [2:0] cfg_index = '0;
    logic [16:0] cfg_data = '0;

    sine_note_adsr_synth DUT (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // reference state
    logic [16:0] rate_r;
    logic [15:0] att_r, dec_r, rel_r, sus_r;
    logic [31:0] elapsed, phase, incr;
    logic [23:0] pos, len;
    logic [15:0] amp;
    logic silent, running;

    smp_t sample_queue[$];
    int errors = 0, n_samples = 0, n_notes = 0, idle_cycles = 0;
    bit stalls_on = 1'b1;

    function automatic logic [31:0] pitch_q16(input logic [3:0] s);
        case (s)
            4'd0: return 32'd548668578;   4'd1: return 32'd581294109;
            4'd2: return 32'd615859655;   4'd3: return 32'd652480576;
            4'd4: return 32'd691279090;   4'd5: return 32'd732384684;
            4'd6: return 32'd775934544;   4'd7: return 32'd822074012;
            4'd8: return 32'd870957077;   4'd9: return 32'd922746880;
            4'd10: return 32'd977616265;  default: return 32'd1035748353;
        endcase
    endfunction

    function automatic int sine_lookup(input logic [31:0] ph);
        longint unsigned idx, turn, z, z2, t;
        int unsigned quad;
        idx = ({32'd0, ph} * snas_pkg::SINE_TABLE_DEPTH) >> 32;
        turn = (idx * 65536) / snas_pkg::SINE_TABLE_DEPTH;
        quad = (turn >> 14) & 3;
        z = (turn & 64'h3FFF) << 1;
        if (quad & 1) z = 32768 - z;
        z2 = (z * z) >> 15;
        t = (2320 * z2) >> 15;
        t = 21024 - t;
        t = (t * z2) >> 15;
        t = 51472 - t;
        t = (t * z) >> 15;
        if (t > 32767) t = 32767;
        return (quad & 2) ? -int'(t) : int'(t);
    endfunction

    function automatic int scale_q16(input int v, input longint unsigned k);
        longint unsigned mag;
        longint r;
        mag = (v < 0) ? longint'(-v) : longint'(v);
        r = longint'((mag * k) >> 16);
        return (v < 0) ? int'(-r) : int'(r);
    endfunction

    function automatic longint unsigned env_level(input longint unsigned i,
                                                  input longint unsigned l);
        longint unsigned a, d, r, s;
        a = att_r; d = dec_r; r = rel_r; s = sus_r;
        if (i < a) return (i * 65536) / a;
        if (i < a + d) return 65536 - ((i - a) * (65536 - s)) / d;
        if (i + r < l) return s;
        return (s * (l - i)) / r;
    endfunction

    task automatic synth_reset();
        rate_r = 17'd16000; att_r = 16'd800; dec_r = 16'd1600; rel_r = 16'd3200;
        sus_r = 16'd52429;
        elapsed = '0; phase = '0; incr = '0; pos = '0; len = '0; amp = '0;
        silent = 1'b0; running = 1'b0;
    endtask

    // advance the model by one accepted event; returns 1 with a sample on ticks
    function automatic bit synth_step(input ev_t e, output smp_t o);
        longint unsigned freq, rt;
        int raw, v;
        o = '0;
        if (e.cmd == snas_pkg::CMD_LOAD) begin
            silent = e.sil;
            len = e.dur;
            pos = '0;
            running = (e.dur != 0);
            if (e.sil) begin
                incr = '0; amp = '0; phase = '0;
            end else begin
                freq = pitch_q16(4'(e.note % 12)) >> (10 - e.note / 12);
                rt = (rate_r == 0) ? 1 : rate_r;
                incr = 32'((freq << 16) / rt);
                amp = 16'((e.vel * 45875 + 63) / 127);
                phase = incr * elapsed;
            end
            return 1'b0;
        end
        if (!running) return 1'b1;
        v = 0;
        o.last = ({8'd0, pos} + 1) >= len;
        if (!silent) begin
            raw = scale_q16(sine_lookup(phase), amp);
            v = scale_q16(raw, env_level(pos, len));
        end
        o.smp = 16'(v);
        o.act = 1'b1;
        pos = pos + 1;
        phase = phase + incr;
        elapsed = elapsed + 1;
        if (o.last) running = 1'b0;
        return 1'b1;
    endfunction

    function automatic int gap_len();
        if (!stalls_on || $urandom_range(0, 3) == 0) return 0;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 3);
    endfunction

    // valid stays high between back-to-back transfers; it drops only for a gap
    task automatic send(input ev_t e);
        smp_t o;
        int n;
        n = gap_len();
        if (n > 0) begin
            s_valid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= e.cmd;
        s_is_silence <= e.sil;
        s_note_number <= e.note;
        s_velocity <= e.vel;
        s_duration_samples <= e.dur;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (synth_step(e, o)) sample_queue.push_back(o);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sample_queue.size() != 0) @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [16:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            snas_pkg::REG_RATE: rate_r = val;
            snas_pkg::REG_ATT:  att_r = val[15:0];
            snas_pkg::REG_DEC:  dec_r = val[15:0];
            snas_pkg::REG_REL:  rel_r = val[15:0];
            snas_pkg::REG_SUS:  sus_r = val[15:0];
            default: ;
        endcase
    endtask

    function automatic ev_t tick();
        ev_t e;
        e = '0;
        e.cmd = snas_pkg::CMD_TICK;
        e.sil = 1'($urandom);
        e.note = 7'($urandom);
        e.vel = 7'($urandom);
        e.dur = 24'($urandom);
        return e;
    endfunction

    function automatic ev_t load(input bit sil, input logic [6:0] nt, input logic [6:0] vl,
                                 input logic [23:0] d);
        ev_t e;
        e.cmd = snas_pkg::CMD_LOAD; e.sil = sil; e.note = nt; e.vel = vl; e.dur = d;
        return e;
    endfunction

    // result side: random back-pressure while stalls are on, and in-order compare
    always @(posedge aclk) begin
        smp_t w;
        if (aresetn && m_valid && m_ready) begin
            n_samples++;
            if (sample_queue.size() == 0) begin
                errors++;
                $display("%0t: unexpected sample %0d last %0b active %0b", $time, m_sample,
                         m_last_of_event, m_active);
            end else begin
                w = sample_queue.pop_front();
                if (w.smp !== m_sample || w.last !== m_last_of_event || w.act !== m_active) begin
                    errors++;
                    $display("%0t: expected sample %0d last %0b active %0b, got %0d %0b %0b",
                             $time, w.smp, w.last, w.act, m_sample, m_last_of_event,
                             m_active);
                end
            end
        end
        m_ready <= stalls_on ? ($urandom_range(0, 9) < 7) : 1'b1;
    end

    // watchdog on stalled traffic
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready) ||
            (!s_valid && sample_queue.size() == 0))
            idle_cycles <= 0;
        else if (idle_cycles + 1 >= WATCHDOG) begin
            $display("FAIL sine_note_adsr_synth");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    row_t rows[$];

    task automatic add_row(input ev_t e, input logic fx, input smp_t w);
        row_t r;
        r.ev = e; r.fixed = fx; r.want = w;
        rows.push_back(r);
    endtask

    initial begin
        ev_t e;
        smp_t got, idle_smp, last_silence;
        int k, n_ev, pending;
        synth_reset();
        idle_smp = '0;
        last_silence = '{smp: 16'sd0, last: 1'b1, act: 1'b1};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table; rows marked fixed carry a hand-written expected sample
        add_row(tick(), 1'b1, idle_smp);
        add_row(load(1'b0, 7'd69, 7'd127, 24'd0), 1'b0, idle_smp);
        add_row(tick(), 1'b1, idle_smp);
        add_row(load(1'b1, 7'd127, 7'd127, 24'd1), 1'b0, idle_smp);
        add_row(tick(), 1'b1, last_silence);
        add_row(tick(), 1'b1, idle_smp);
        add_row(load(1'b0, 7'd0, 7'd0, 24'd2), 1'b0, idle_smp);
        add_row(tick(), 1'b0, idle_smp);
        add_row(tick(), 1'b0, idle_smp);
        add_row(load(1'b0, 7'd127, 7'd127, 24'hFFFFFF), 1'b0, idle_smp);
        add_row(tick(), 1'b0, idle_smp);
        add_row(tick(), 1'b0, idle_smp);
        add_row(load(1'b0, 7'd69, 7'd100, 24'd3), 1'b0, idle_smp);  // replaces running note
        for (k = 0; k < 4; k++) add_row(tick(), 1'b0, idle_smp);
        add_row(load(1'b1, 7'd5, 7'd9, 24'd2), 1'b0, idle_smp);
        add_row(tick(), 1'b0, idle_smp);
        add_row(tick(), 1'b1, last_silence);
        foreach (rows[i]) begin
            if (rows[i].fixed && rows[i].ev.cmd == snas_pkg::CMD_TICK) begin
                e = rows[i].ev;
                send(e);
                got = sample_queue[$];
                if (got != rows[i].want) begin
                    errors++;
                    $display("%0t: table row %0d expected %0d/%0b/%0b, model gives %0d/%0b/%0b",
                             $time, i, rows[i].want.smp, rows[i].want.last,
                             rows[i].want.act, got.smp, got.last, got.act);
                end
            end else
                send(rows[i].ev);
        end
        drain();

        // register phases: extremes, zero lengths, a zero rate, then random settings
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin
                    write_reg(snas_pkg::REG_RATE, 17'd8000);
                    write_reg(snas_pkg::REG_ATT, 16'd1);
                    write_reg(snas_pkg::REG_DEC, 16'd1);
                    write_reg(snas_pkg::REG_REL, 16'd1);
                    write_reg(snas_pkg::REG_SUS, 16'hFFFF);
                end
                1: begin
                    write_reg(snas_pkg::REG_RATE, 17'd96000);
                    write_reg(snas_pkg::REG_ATT, 16'hFFFF);
                    write_reg(snas_pkg::REG_DEC, 16'hFFFF);
                    write_reg(snas_pkg::REG_REL, 16'hFFFF);
                    write_reg(snas_pkg::REG_SUS, 16'd0);
                end
                2: begin
                    write_reg(snas_pkg::REG_RATE, 17'h1FFFF);
                    write_reg(snas_pkg::REG_ATT, 16'd0);
                    write_reg(snas_pkg::REG_DEC, 16'd0);
                    write_reg(snas_pkg::REG_REL, 16'd0);
                    write_reg(snas_pkg::REG_SUS, 16'd30000);
                end
                3: write_reg(snas_pkg::REG_RATE, 17'd0);
                default: begin
                    write_reg(snas_pkg::REG_RATE, 17'($urandom_range(8000, 96000)));
                    write_reg(snas_pkg::REG_ATT, 16'($urandom_range(1, 12)));
                    write_reg(snas_pkg::REG_DEC, 16'($urandom_range(1, 12)));
                    write_reg(snas_pkg::REG_REL, 16'($urandom_range(1, 12)));
                    write_reg(snas_pkg::REG_SUS, 16'($urandom));
                end
            endcase
            cfg_valid <= 1'b0;
            stalls_on = (ph != 4);
            n_ev = 0;
            while (n_ev < 200) begin
                if ($urandom_range(0, 9) < 8) begin
                    // a well-formed event: load then its ticks, sometimes cut short or run past its end
                    e = load($urandom_range(0, 4) == 0, 7'($urandom), 7'($urandom),
                             ($urandom_range(0, 15) == 0) ? 24'($urandom) :
                             24'($urandom_range(0, 30)));
                    send(e); n_ev++; n_notes++;
                    pending = (e.dur > 40) ? 40 : e.dur;
                    if ($urandom_range(0, 5) == 0) pending = $urandom_range(0, pending);
                    else pending = pending + $urandom_range(0, 2);
                    for (k = 0; k < pending; k++) begin
                        send(tick()); n_ev++;
                    end
                end else begin
                    send(tick()); n_ev++;
                end
            end
            drain();
        end

        $display("Covered %0d loads and %0d checked samples over 7 register settings.",
                 n_notes, n_samples);
        if (errors == 0)
            $display("PASS sine_note_adsr_synth");
        else
            $display("FAIL sine_note_adsr_synth");
        $finish;
    end
endmodule
`default_nettype wire
